[hdl/vmcs_pkg.sv]
// Package of shared types and constants for the void measure column selector.
package vmcs_pkg;

  // Fixed field widths of the input and result words.
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned COL_IDX_W = 4;
  localparam int unsigned VM_W      = 13;
  localparam int unsigned NCOL_W    = 5;

  // Reset value of the column count register.
  localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 5'd16;

  // Input word: one matrix row and its end-of-matrix mark.
  typedef struct packed {
    logic [ROW_W-1:0] row_bits;
    logic             last_row;
  } in_word_t;

  // Result word: one selected column.
  typedef struct packed {
    logic [COL_IDX_W-1:0] col_index;
    logic [VM_W-1:0]      max_measure;
    logic                 overflow;
    logic                 last_of_run;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_CALC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // Controls broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic upd;    // fold the current row into the accumulators
    logic clr;    // clear the accumulators for the next matrix
    logic calc;   // load the measure register from the accumulators
    logic shift;  // move measures one cell towards the head
  } cell_ctrl_t;

endpackage

[hdl/vmcs_cell.sv]
// One column cell: accumulators for one column and a stage of the measure chain.
module vmcs_cell import vmcs_pkg::*; #(
  parameter int unsigned NCELL = 16,
  parameter int unsigned CW    = 9,
  parameter int unsigned SW    = 5,
  parameter int unsigned C     = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic [NCELL-1:0] row_i,
  input  logic [SW-1:0]    pop_i,
  input  logic [VM_W-1:0]  v_i,
  output logic [VM_W-1:0]  v_o
);

  localparam int unsigned PW = CW + SW;

  logic [CW-1:0]    count_q, count_d;
  logic [NCELL-1:0] mask_q, mask_d;
  logic [PW-1:0]    sum_q, sum_d;
  logic [VM_W-1:0]  v_q, v_d;

  logic [NCELL-1:0]   self_bit;
  logic [SW-1:0]      span;
  logic [PW-1:0]      prod;
  logic [PW-1:0]      diff;
  logic [PW+VM_W-1:0] diff_ext;

  // Accumulator update for rows in which this column is set.
  always_comb begin
    count_d = count_q;
    mask_d  = mask_q;
    sum_d   = sum_q;
    if (ctrl_i.clr) begin
      count_d = '0;
      mask_d  = '0;
      sum_d   = '0;
    end else if (ctrl_i.upd && row_i[C]) begin
      count_d = count_q + CW'(1);
      mask_d  = mask_q | row_i;
      sum_d   = sum_q + PW'(pop_i);
    end
  end

  // Measure: count times the size of the shared set, less the co-occurrences,
  // held at zero when negative and cut to the result width.
  always_comb begin
    self_bit = '0;
    self_bit[C] = 1'b1;
    span     = SW'($countones(mask_q | self_bit));
    prod     = PW'(count_q) * PW'(span);
    diff     = (prod > sum_q) ? (prod - sum_q) : '0;
    diff_ext = {{VM_W{1'b0}}, diff};
  end

  // The measure register doubles as a stage of the shift chain.
  always_comb begin
    v_d = v_q;
    if (ctrl_i.calc) begin
      v_d = diff_ext[VM_W-1:0];
    end else if (ctrl_i.shift) begin
      v_d = v_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      mask_q  <= '0;
      sum_q   <= '0;
    end else begin
      count_q <= count_d;
      mask_q  <= mask_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

[hdl/void_measure_column_select_top.sv]
// Top level of the void measure column selector: sequencer, cell chain and output register.
//
//   channel  direction  handshake              word
//   in       input      in_valid_i/in_stall_o  in_word_i  (row_bits, last_row)
//   out      output     out_valid_o/out_stall_i out_word_o (col_index, max_measure,
//                                              overflow, last_of_run)
//   cfg      input      cfg_we_i               cfg_wdata_i (num_cols)
//
// Every cell folds an accepted row word in at once.
// After the last row the block forms the measures, rotates them once around
// the chain past its head to find the maximum, then shifts them out for the
// columns in use; in_stall_o is high throughout. A stall on the output holds
// the shift chain.
// Reset clears all accumulators and sets the column count to 16.
module void_measure_column_select_top import vmcs_pkg::*; #(
  parameter int unsigned MAX_COLS = 16,
  parameter int unsigned MAX_ROWS = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              cfg_we_i,
  input  logic [NCOL_W-1:0] cfg_wdata_i
);

  localparam int unsigned NCELL = (MAX_COLS < 16) ? MAX_COLS : 16;
  localparam int unsigned CW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW    = $clog2(NCELL + 1);

  state_e             state_q, state_d;
  logic [NCOL_W-1:0]  num_cols_q;
  logic [CW-1:0]      rows_seen_q, rows_seen_d;
  logic               dropped_q, dropped_d;
  logic               ovf_q, ovf_d;
  logic [SW-1:0]      n_q, n_d;
  logic [SW-1:0]      idx_q, idx_d;
  logic [SW-1:0]      last_idx_q, last_idx_d;
  logic [VM_W-1:0]    best_q, best_d;
  logic               out_vq;
  out_word_t          out_q;

  logic               accept, full, advance, emit_hit;
  logic [NCOL_W-1:0]  n_act;
  logic [ROW_W-1:0]   col_mask;
  logic [ROW_W-1:0]   row_m16;
  logic [NCELL-1:0]   row_m;
  logic [SW-1:0]      row_pop;
  logic [VM_W-1:0]    head_v;
  cell_ctrl_t         ctrl;
  logic [VM_W-1:0]    v_chain [NCELL];

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NUM_COLS_RESET;
    end else if (cfg_we_i) begin
      num_cols_q <= cfg_wdata_i;
    end
  end

  // Effective column count and the masked row that goes to the cells.
  always_comb begin
    if (num_cols_q == '0) begin
      n_act = NCOL_W'(1);
    end else if (num_cols_q > NCOL_W'(NCELL)) begin
      n_act = NCOL_W'(NCELL);
    end else begin
      n_act = num_cols_q;
    end
    col_mask = ROW_W'((32'd1 << n_act) - 32'd1);
    row_m16  = in_word_i.row_bits & col_mask;
    row_m    = row_m16[NCELL-1:0];
    row_pop  = SW'($countones(row_m));
  end

  assign in_stall_o = (state_q != ST_ACC);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (rows_seen_q == CW'(MAX_ROWS));
  assign advance    = !out_vq || !out_stall_i;
  assign head_v     = v_chain[0];
  assign emit_hit   = (state_q == ST_EMIT) && (idx_q < n_q) && (head_v == best_q);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    rows_seen_d = rows_seen_q;
    dropped_d   = dropped_q;
    ovf_d       = ovf_q;
    n_d         = n_q;
    idx_d       = idx_q;
    last_idx_d  = last_idx_q;
    best_d      = best_q;
    ctrl        = '0;
    case (state_q)
      ST_ACC: begin
        if (accept) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            ctrl.upd    = 1'b1;
            rows_seen_d = rows_seen_q + CW'(1);
          end
          if (in_word_i.last_row) begin
            ovf_d   = dropped_q || full;
            n_d     = SW'(n_act);
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        ctrl.calc   = 1'b1;
        ctrl.clr    = 1'b1;
        rows_seen_d = '0;
        dropped_d   = 1'b0;
        idx_d       = '0;
        best_d      = '0;
        last_idx_d  = '0;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        if (idx_q < n_q) begin
          if (head_v > best_q) begin
            best_d     = head_v;
            last_idx_d = idx_q;
          end else if (head_v == best_q) begin
            last_idx_d = idx_q;
          end
        end
        if (idx_q == SW'(NCELL - 1)) begin
          idx_d   = '0;
          state_d = ST_EMIT;
        end else begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_EMIT: begin
        if (advance) begin
          ctrl.shift = 1'b1;
          idx_d      = idx_q + SW'(1);
          if (idx_q == n_q - SW'(1)) begin
            state_d = ST_ACC;
          end
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      rows_seen_q <= '0;
      dropped_q   <= 1'b0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      idx_q       <= '0;
      last_idx_q  <= '0;
      best_q      <= '0;
    end else begin
      state_q     <= state_d;
      rows_seen_q <= rows_seen_d;
      dropped_q   <= dropped_d;
      ovf_q       <= ovf_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      last_idx_q  <= last_idx_d;
      best_q      <= best_d;
    end
  end

  // Chain of column cells; the head feeds back to the tail so that a full
  // scan leaves every measure where it started.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    logic [VM_W-1:0] v_next;
    if (k == NCELL - 1) begin : g_tail
      assign v_next = v_chain[0];
    end else begin : g_body
      assign v_next = v_chain[k+1];
    end
    vmcs_cell #(
      .NCELL(NCELL),
      .CW   (CW),
      .SW   (SW),
      .C    (k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .row_i (row_m),
      .pop_i (row_pop),
      .v_i   (v_next),
      .v_o   (v_chain[k])
    );
  end

  // Output register: it advances whenever the slot is free or being taken, and loads a word on an emission hit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (advance) begin
      out_vq <= emit_hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit_hit) begin
      out_q.col_index   <= COL_IDX_W'(idx_q);
      out_q.max_measure <= best_q;
      out_q.overflow    <= ovf_q;
      out_q.last_of_run <= (idx_q == last_idx_q);
    end
  end

  assign out_valid_o = out_vq;
  assign out_word_o  = out_q;

  // No row is folded in while the measures are being scanned or shifted out.
  a_no_upd_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_ACC) |-> !ctrl.upd)
    else $error("cell update outside accumulation");

  // The row counter never passes the capacity.
  a_rows_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q <= CW'(MAX_ROWS))
    else $error("row counter beyond capacity");

  // A word loaded during emission carries the maximum found by the scan.
  a_emit_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit_hit) |=> (out_valid_o && out_word_o.max_measure == $past(best_q)))
    else $error("emitted measure differs from maximum");

  // The last selected index never lies beyond the columns in use.
  a_last_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (last_idx_q < n_q))
    else $error("last selected index out of range");

endmodule
